[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, also while reset is held
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/usts_pkg.sv]
// Package for the USART status and transmit control block.
// Types, command codes and register bit positions; no dependencies.
package usts_pkg;

    // Request type codes on the input channel
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Register select codes
    localparam logic [1:0] SEL_UCR = 2'd0;
    localparam logic [1:0] SEL_RSR = 2'd1;
    localparam logic [1:0] SEL_TSR = 2'd2;
    localparam logic [1:0] SEL_UDR = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WORD_TICKS = 1'b0;
    localparam logic CFG_RX_ERR_EN  = 1'b1;

    // Fixed masks
    localparam logic [7:0] LOOPBACK_BITS  = 8'b0000_0110;
    localparam logic [7:0] CHAR_SIZE_BITS = 8'b0110_0000;
    localparam logic [7:0] FULL_BYTE      = 8'hff;
    localparam logic [7:0] UCR_KEEP       = 8'b1111_1110;

    // Status bit positions
    localparam int RSR_ENABLE  = 0;
    localparam int RSR_OVERRUN = 6;
    localparam int RSR_FULL    = 7;
    localparam int TSR_ENABLE  = 0;
    localparam int TSR_BREAK   = 3;
    localparam int TSR_END     = 4;
    localparam int TSR_AUTO_TA = 5;
    localparam int TSR_UNDERRUN = 6;
    localparam int TSR_EMPTY   = 7;

    // Classified command passed from front to back
    typedef enum logic [3:0] {
        OP_NOP,
        OP_RD_UCR,
        OP_RD_RSR,
        OP_RD_TSR,
        OP_RD_UDR,
        OP_WR_UCR,
        OP_WR_RSR,
        OP_WR_TSR,
        OP_WR_UDR,
        OP_TICK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_tx_empty;
        logic       irq_tx_error;
        logic       irq_rx_full;
        logic       irq_rx_error;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       break_level;
    } res_t;

endpackage

[sv/usts_fifo.sv]
// Small flop-based queue with registered head, used between stages.
// No package dependencies.
module usts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/usts_front.sv]
// Front end: takes bus requests and classifies them into commands.
// Depends on usts_pkg.
module usts_front (
    input  logic            push,
    input  logic [1:0]      req_type,
    input  logic [1:0]      reg_sel,
    input  logic [7:0]      wr_data,
    input  logic            q_full,
    output logic            q_wr,
    output usts_pkg::cmd_t  cmd
);

    assign q_wr = push && !q_full;

    // Decode request type and register select into one operation
    always_comb
    begin
        cmd.data = wr_data;
        cmd.op   = usts_pkg::OP_NOP;
        unique case (req_type)
            usts_pkg::REQ_READ:
            begin
                unique case (reg_sel)
                    usts_pkg::SEL_UCR: cmd.op = usts_pkg::OP_RD_UCR;
                    usts_pkg::SEL_RSR: cmd.op = usts_pkg::OP_RD_RSR;
                    usts_pkg::SEL_TSR: cmd.op = usts_pkg::OP_RD_TSR;
                    default:           cmd.op = usts_pkg::OP_RD_UDR;
                endcase
            end
            usts_pkg::REQ_WRITE:
            begin
                unique case (reg_sel)
                    usts_pkg::SEL_UCR: cmd.op = usts_pkg::OP_WR_UCR;
                    usts_pkg::SEL_RSR: cmd.op = usts_pkg::OP_WR_RSR;
                    usts_pkg::SEL_TSR: cmd.op = usts_pkg::OP_WR_TSR;
                    default:           cmd.op = usts_pkg::OP_WR_UDR;
                endcase
            end
            usts_pkg::REQ_TICK: cmd.op = usts_pkg::OP_TICK;
            default:            cmd.op = usts_pkg::OP_NOP;
        endcase
    end

endmodule

[sv/usts_exec.sv]
// Back end: holds the USART registers and countdowns, executes commands.
// Depends on usts_pkg.
module usts_exec #(
    parameter int TICK_COUNT_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [TICK_COUNT_BITS-1:0] cfg_data,
    input  logic                       cmd_valid,
    input  usts_pkg::cmd_t             cmd,
    output logic                       cmd_pop,
    input  logic                       res_full,
    output logic                       res_push,
    output usts_pkg::res_t             res
);

    localparam int CNT_W = TICK_COUNT_BITS + 1;

    logic [TICK_COUNT_BITS-1:0] word_ticks_reg;
    logic                       rx_err_en_reg;
    logic [7:0]                 ucr_reg, ucr_next;
    logic [7:0]                 rsr_reg, rsr_next;
    logic [7:0]                 tsr_reg, tsr_next;
    logic [7:0]                 rx_byte_reg, rx_byte_next;
    logic                       overrun_reg, overrun_next;
    logic [CNT_W-1:0]           sent_cnt_reg, sent_cnt_next;
    logic [CNT_W-1:0]           loop_cnt_reg, loop_cnt_next;
    logic [CNT_W-1:0]           brk_cnt_reg, brk_cnt_next;
    logic [7:0]                 loop_byte_reg, loop_byte_next;
    logic [CNT_W-1:0]           word_time;
    logic [7:0]                 v;

    assign cmd_pop  = cmd_valid && !res_full;
    assign res_push = cmd_pop;

    // Zero word time acts as one
    assign word_time = (word_ticks_reg == '0) ? CNT_W'(1) : {1'b0, word_ticks_reg};

    // Execute one command
    always_comb
    begin
        ucr_next       = ucr_reg;
        rsr_next       = rsr_reg;
        tsr_next       = tsr_reg;
        rx_byte_next   = rx_byte_reg;
        overrun_next   = overrun_reg;
        sent_cnt_next  = sent_cnt_reg;
        loop_cnt_next  = loop_cnt_reg;
        brk_cnt_next   = brk_cnt_reg;
        loop_byte_next = loop_byte_reg;
        v              = cmd.data;
        res            = '0;

        unique case (cmd.op)
            usts_pkg::OP_RD_UCR: res.read_data = ucr_reg;
            usts_pkg::OP_RD_RSR:
            begin
                if (!overrun_reg)
                begin
                    rsr_next[usts_pkg::RSR_OVERRUN] = 1'b0;
                end
                res.read_data = rsr_next;
            end
            usts_pkg::OP_RD_TSR:
            begin
                tsr_next[usts_pkg::TSR_UNDERRUN] = 1'b0;
                res.read_data = tsr_next;
            end
            usts_pkg::OP_RD_UDR:
            begin
                rsr_next[usts_pkg::RSR_FULL] = 1'b0;
                if (overrun_reg)
                begin
                    rsr_next[usts_pkg::RSR_OVERRUN] = 1'b1;
                    overrun_next = 1'b0;
                    res.irq_rx_error = rx_err_en_reg;
                    res.irq_rx_full  = !rx_err_en_reg;
                end
                res.read_data = rx_byte_reg;
            end
            usts_pkg::OP_WR_UCR: ucr_next = cmd.data & usts_pkg::UCR_KEEP;
            usts_pkg::OP_WR_RSR:
            begin
                // Clearing the enable while on wipes the whole write
                if (!v[0] && rsr_reg[usts_pkg::RSR_ENABLE])
                begin
                    v = '0;
                end
                rsr_next = {rsr_reg[usts_pkg::RSR_FULL], v[6:0]};
            end
            usts_pkg::OP_WR_TSR:
            begin
                if (v[0] && !tsr_reg[usts_pkg::TSR_ENABLE])
                begin
                    v[usts_pkg::TSR_END] = 1'b0;
                end
                v = {tsr_reg[usts_pkg::TSR_EMPTY], v[6:0]};
                // Break bit change starts or ends a break
                if (v[usts_pkg::TSR_BREAK] != tsr_reg[usts_pkg::TSR_BREAK])
                begin
                    if (v[usts_pkg::TSR_BREAK])
                    begin
                        sent_cnt_next = '0;
                        brk_cnt_next  = word_time;
                    end
                    else
                    begin
                        brk_cnt_next = '0;
                        if (!tsr_reg[usts_pkg::TSR_EMPTY])
                        begin
                            sent_cnt_next = CNT_W'(2);
                        end
                    end
                end
                tsr_next = v;
            end
            usts_pkg::OP_WR_UDR:
            begin
                if (tsr_reg[usts_pkg::TSR_ENABLE] && !tsr_reg[usts_pkg::TSR_BREAK])
                begin
                    tsr_next[usts_pkg::TSR_EMPTY] = 1'b0;
                    sent_cnt_next = word_time;
                    if ((tsr_reg & usts_pkg::LOOPBACK_BITS) == usts_pkg::LOOPBACK_BITS)
                    begin
                        loop_cnt_next  = word_time + 1'b1;
                        loop_byte_next = cmd.data;
                    end
                    else
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = cmd.data & (usts_pkg::FULL_BYTE
                                       >> ucr_reg[6:5]);
                    end
                end
            end
            usts_pkg::OP_TICK:
            begin
                // Transmit done
                if (sent_cnt_reg != '0)
                begin
                    sent_cnt_next = sent_cnt_reg - 1'b1;
                    if (sent_cnt_next == '0)
                    begin
                        tsr_next[usts_pkg::TSR_EMPTY] = 1'b1;
                        res.irq_tx_empty = 1'b1;
                        if (!tsr_next[usts_pkg::TSR_ENABLE])
                        begin
                            tsr_next[usts_pkg::TSR_END] = 1'b1;
                            res.irq_tx_error = 1'b1;
                            if (tsr_next[usts_pkg::TSR_AUTO_TA])
                            begin
                                rsr_next[usts_pkg::RSR_ENABLE] = 1'b1;
                            end
                        end
                    end
                end
                // Loopback delivery
                if (loop_cnt_reg != '0)
                begin
                    loop_cnt_next = loop_cnt_reg - 1'b1;
                    if (loop_cnt_next == '0 && rsr_next[usts_pkg::RSR_ENABLE])
                    begin
                        if (!rsr_next[usts_pkg::RSR_FULL])
                        begin
                            rx_byte_next = loop_byte_reg;
                            overrun_next = 1'b0;
                        end
                        else
                        begin
                            overrun_next = 1'b1;
                        end
                        rsr_next[5:2] = 4'b0000;
                        rsr_next[usts_pkg::RSR_FULL] = 1'b1;
                        res.irq_rx_full = 1'b1;
                    end
                end
                // Break boundary, repeats each word time
                if (brk_cnt_reg != '0)
                begin
                    brk_cnt_next = brk_cnt_reg - 1'b1;
                    if (brk_cnt_next == '0)
                    begin
                        if (!tsr_next[usts_pkg::TSR_UNDERRUN])
                        begin
                            res.irq_tx_error = 1'b1;
                        end
                        brk_cnt_next = word_time;
                    end
                end
            end
            default: ;
        endcase
        res.break_level = tsr_next[usts_pkg::TSR_BREAK];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_ticks_reg <= '1;
            rx_err_en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                usts_pkg::CFG_WORD_TICKS: word_ticks_reg <= cfg_data;
                default:                  rx_err_en_reg  <= cfg_data[0];
            endcase
        end
    end

    // USART state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ucr_reg       <= '0;
            rsr_reg       <= '0;
            tsr_reg       <= '0;
            rx_byte_reg   <= '0;
            overrun_reg   <= 1'b0;
            sent_cnt_reg  <= '0;
            loop_cnt_reg  <= '0;
            brk_cnt_reg   <= '0;
            loop_byte_reg <= '0;
        end
        else if (cmd_pop)
        begin
            ucr_reg       <= ucr_next;
            rsr_reg       <= rsr_next;
            tsr_reg       <= tsr_next;
            rx_byte_reg   <= rx_byte_next;
            overrun_reg   <= overrun_next;
            sent_cnt_reg  <= sent_cnt_next;
            loop_cnt_reg  <= loop_cnt_next;
            brk_cnt_reg   <= brk_cnt_next;
            loop_byte_reg <= loop_byte_next;
        end
    end

endmodule

[sv/usart_status_and_transmit_control.sv]
// Top level of the USART status and transmit control block.
// Depends on usts_pkg, usts_front, usts_fifo and usts_exec.
//
//  channel   handshake          payload
//  request   push / full        req_type, reg_sel, wr_data
//  result    empty / pop        read_data, irq_*, tx_valid, tx_byte, break_level
//  config    cfg_we             cfg_index, cfg_data
//
// One item per cycle sustained unless the result side stalls; a result is poppable
// once registered in the command queue and then, by the execute step, in the result queue.
// Throughput is set by the execute step on the register file.
// Reset clears the USART registers, countdowns and both queues, and sets the word time to all ones.
// A stalled result side fills the result queue, then the command queue, then
// raises full.
module usart_status_and_transmit_control #(
    parameter int TICK_COUNT_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [TICK_COUNT_BITS-1:0] cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 req_type,
    input  logic [1:0]                 reg_sel,
    input  logic [7:0]                 wr_data,
    output logic                       empty,
    input  logic                       pop,
    output logic [7:0]                 read_data,
    output logic                       irq_tx_empty,
    output logic                       irq_tx_error,
    output logic                       irq_rx_full,
    output logic                       irq_rx_error,
    output logic                       tx_valid,
    output logic [7:0]                 tx_byte,
    output logic                       break_level
);

    localparam int CMD_W = $bits(usts_pkg::cmd_t);
    localparam int RES_W = $bits(usts_pkg::res_t);

    usts_pkg::cmd_t cmd_in, cmd_out;
    usts_pkg::res_t res_in, res_out;
    logic           cmd_wr, cmd_empty, cmd_pop;
    logic           res_full, res_push;

    // Classify incoming requests
    usts_front u_front (
        .push     (push),
        .req_type (req_type),
        .reg_sel  (reg_sel),
        .wr_data  (wr_data),
        .q_full   (full),
        .q_wr     (cmd_wr),
        .cmd      (cmd_in)
    );

    // Command queue between front and back
    usts_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // Execute against register state
    usts_exec #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue
    usts_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign read_data    = res_out.read_data;
    assign irq_tx_empty = res_out.irq_tx_empty;
    assign irq_tx_error = res_out.irq_tx_error;
    assign irq_rx_full  = res_out.irq_rx_full;
    assign irq_rx_error = res_out.irq_rx_error;
    assign tx_valid     = res_out.tx_valid;
    assign tx_byte      = res_out.tx_byte;
    assign break_level  = res_out.break_level;

endmodule

[sv/usts_checker.sv]
// Port-level checks for the USART status and transmit control block.
// Depends on assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module usts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] read_data,
    input logic       irq_tx_empty,
    input logic       irq_tx_error,
    input logic       irq_rx_full,
    input logic       irq_rx_error,
    input logic       tx_valid,
    input logic [7:0] tx_byte,
    input logic       break_level
);

    logic [16:0] head_bits;
    logic        any_irq;
    logic        rx_irq_both;

    // Collected views of the result head
    assign head_bits   = {read_data, tx_byte, break_level};
    assign any_irq     = irq_tx_empty || irq_tx_error || irq_rx_full || irq_rx_error;
    assign rx_irq_both = irq_rx_full && irq_rx_error;

    // Nothing to pop while reset is held
    `ASSERT_ALWAYS(a_reset_empty, !rst_n |-> empty, "result queue not empty in reset")

    // A waiting result keeps its read data, tx byte and break level until transferred
    `ASSERT_CLK(a_hold,
        (!empty && !pop) |=> $stable(head_bits),
        "result changed while stalled")

    // A sent character comes only from a data write: no read data, no interrupts
    `ASSERT_CLK(a_tx_alone,
        (!empty && tx_valid) |-> (read_data == 8'd0 && !any_irq),
        "transmit mixed with other results")

    // Overrun reports as one interrupt or the other, never both; tx_byte is zero when idle
    `ASSERT_CLK(a_rx_irq_excl,
        !empty |-> (!rx_irq_both && (tx_valid || tx_byte == 8'd0)),
        "bad receive interrupt or stray tx byte")

endmodule

bind usart_status_and_transmit_control usts_checker u_usts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .read_data    (read_data),
    .irq_tx_empty (irq_tx_empty),
    .irq_tx_error (irq_tx_error),
    .irq_rx_full  (irq_rx_full),
    .irq_rx_error (irq_rx_error),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .break_level  (break_level)
);
